/* src/assert_macros.svh */
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on rising edge with async reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/tkbk_pkg.sv */
// -----------------------------------------------------------------------------
// tkbk_pkg
// Types, codes and the quality compare shared by the top-K keeper modules.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkbk_pkg;

	typedef logic signed [31:0] qual_t;
	typedef logic [31:0]        id_t;

	// configuration register indexes
	localparam logic REG_LOWER_IS_BETTER   = 1'b0;
	localparam logic REG_INITIAL_THRESHOLD = 1'b1;

	// input command codes
	localparam logic CMD_OFFER = 1'b0;
	localparam logic CMD_DUMP  = 1'b1;

	localparam qual_t THR_RESET  = 32'sh7FFF_FFFF;
	localparam int    DUMP_LIMIT = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SORT,
		ST_SWEEP,
		ST_DUMP,
		ST_REPLY
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic insert;
		logic sort_en;
		logic rot_en;
		logic cap_thr;
		logic emit_offer;
		logic emit_entry;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic dump;
		logic better;
		logic empty;
		logic step_last;
		logic sweep_hit;
		logic emit_here;
		logic out_free;
	} sts_t;

	// true if quality a ranks strictly better than b
	function automatic logic ranks_better(logic lib, qual_t a, qual_t b);
		return lib ? (a < b) : (a > b);
	endfunction

endpackage

/* src/tkbk_ctrl.sv */
// -----------------------------------------------------------------------------
// tkbk_ctrl
// Sequencer for offer evaluation, sort passes, threshold sweep and dump.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkbk_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  tkbk_pkg::sts_t  sts,
	output tkbk_pkg::ctl_t  ctl
);

	tkbk_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkbk_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			tkbk_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				ctl.accept = in_valid;
				if (in_valid) state_d = tkbk_pkg::ST_EVAL;
			end
			tkbk_pkg::ST_EVAL: begin
				if (sts.dump) begin
					state_d = sts.empty ? tkbk_pkg::ST_REPLY : tkbk_pkg::ST_DUMP;
				end else if (sts.better) begin
					ctl.insert = 1'b1;
					state_d    = tkbk_pkg::ST_SORT;
				end else begin
					state_d = tkbk_pkg::ST_REPLY;
				end
			end
			tkbk_pkg::ST_SORT: begin
				ctl.sort_en = 1'b1;
				if (sts.step_last) state_d = tkbk_pkg::ST_SWEEP;
			end
			tkbk_pkg::ST_SWEEP: begin
				ctl.rot_en  = 1'b1;
				ctl.cap_thr = sts.sweep_hit;
				if (sts.step_last) state_d = tkbk_pkg::ST_REPLY;
			end
			tkbk_pkg::ST_DUMP: begin
				// hold while a result is due but the output slot is busy
				if (!(sts.emit_here && !sts.out_free)) begin
					ctl.rot_en     = 1'b1;
					ctl.emit_entry = sts.emit_here;
					if (sts.step_last) state_d = tkbk_pkg::ST_IDLE;
				end
			end
			tkbk_pkg::ST_REPLY: begin
				if (sts.out_free) begin
					ctl.emit_offer = 1'b1;
					state_d        = tkbk_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tkbk_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* src/tkbk_datapath.sv */
// -----------------------------------------------------------------------------
// tkbk_datapath
// Entry ring with odd-even compare-swap cells, counters, config and output reg.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkbk_datapath #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 cmd,
	input  logic [31:0]          candidate_id,
	input  logic signed [31:0]   quality,
	input  tkbk_pkg::ctl_t       ctl,
	output tkbk_pkg::sts_t       sts,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic                 accepted,
	output logic [4:0]           entry_count,
	output logic signed [31:0]   threshold,
	output logic                 entry_valid,
	output logic [3:0]           rank,
	output logic [31:0]          entry_id,
	output logic signed [31:0]   entry_quality,
	output logic                 last
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EXT_W = CNT_W + 5;
	localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_ENTRIES);
	localparam logic [EXT_W-1:0] DUMP_MAX  = EXT_W'(tkbk_pkg::DUMP_LIMIT);

	logic               lib_q;
	tkbk_pkg::qual_t    thr_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   step_q;
	logic               dump_q;
	logic               better_q;
	tkbk_pkg::id_t      cand_id_q;
	tkbk_pkg::qual_t    cand_qual_q;
	logic               out_valid_q;

	tkbk_pkg::id_t      ids_q   [MAX_ENTRIES];
	tkbk_pkg::qual_t    quals_q [MAX_ENTRIES];
	tkbk_pkg::id_t      sort_ids   [MAX_ENTRIES];
	tkbk_pkg::qual_t    sort_quals [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] swap;

	logic               full;
	logic [IDX_W-1:0]   ins_idx;
	logic [EXT_W-1:0]   step_ext;
	logic [EXT_W-1:0]   count_ext;
	logic [EXT_W-1:0]   dump_n;

	assign full      = (count_q == CNT_FULL);
	assign ins_idx   = full ? STEP_LAST : count_q[IDX_W-1:0];
	assign step_ext  = EXT_W'(step_q);
	assign count_ext = EXT_W'(count_q);
	assign dump_n    = (count_ext < DUMP_MAX) ? count_ext : DUMP_MAX;

	// config registers and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lib_q <= 1'b1;
			thr_q <= tkbk_pkg::THR_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tkbk_pkg::REG_LOWER_IS_BETTER: lib_q <= cfg_data[0];
					tkbk_pkg::REG_INITIAL_THRESHOLD: begin
						// only loads while the list is empty
						if (count_q == '0) thr_q <= cfg_data;
					end
					default: ;
				endcase
			end
			if (ctl.cap_thr) thr_q <= quals_q[0];
		end
	end

	// transaction capture, count and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			step_q   <= '0;
			dump_q   <= 1'b0;
			better_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				dump_q   <= (cmd == tkbk_pkg::CMD_DUMP);
				better_q <= tkbk_pkg::ranks_better(lib_q, quality, thr_q);
			end
			if (ctl.insert && !full) count_q <= count_q + CNT_W'(1);
			if (ctl.sort_en || ctl.rot_en) begin
				step_q <= (step_q == STEP_LAST) ? '0 : step_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cand_id_q   <= candidate_id;
			cand_qual_q <= quality;
		end
	end

	// compare-swap cells: pair (i, i+1) on passes of matching parity
	genvar gi;
	generate
		for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
			if (gi < MAX_ENTRIES - 1) begin : g_cmp
				assign swap[gi] = (1'(gi) == step_q[0]) &&
					(CNT_W'(gi + 1) < count_q) &&
					tkbk_pkg::ranks_better(lib_q, quals_q[gi+1], quals_q[gi]);
			end else begin : g_end
				assign swap[gi] = 1'b0;
			end

			if (MAX_ENTRIES == 1) begin : g_only
				always_comb begin
					sort_ids[gi]   = ids_q[gi];
					sort_quals[gi] = quals_q[gi];
				end
			end else if (gi == 0) begin : g_first
				always_comb begin
					sort_ids[gi]   = swap[gi] ? ids_q[gi+1]   : ids_q[gi];
					sort_quals[gi] = swap[gi] ? quals_q[gi+1] : quals_q[gi];
				end
			end else if (gi == MAX_ENTRIES - 1) begin : g_last
				always_comb begin
					sort_ids[gi]   = swap[gi-1] ? ids_q[gi-1]   : ids_q[gi];
					sort_quals[gi] = swap[gi-1] ? quals_q[gi-1] : quals_q[gi];
				end
			end else begin : g_mid
				always_comb begin
					if (swap[gi]) begin
						sort_ids[gi]   = ids_q[gi+1];
						sort_quals[gi] = quals_q[gi+1];
					end else if (swap[gi-1]) begin
						sort_ids[gi]   = ids_q[gi-1];
						sort_quals[gi] = quals_q[gi-1];
					end else begin
						sort_ids[gi]   = ids_q[gi];
						sort_quals[gi] = quals_q[gi];
					end
				end
			end

			// entry storage: insert, sort pass or ring rotation
			always_ff @(posedge clk) begin
				if (ctl.insert) begin
					if (IDX_W'(gi) == ins_idx) begin
						ids_q[gi]   <= cand_id_q;
						quals_q[gi] <= cand_qual_q;
					end
				end else if (ctl.sort_en) begin
					ids_q[gi]   <= sort_ids[gi];
					quals_q[gi] <= sort_quals[gi];
				end else if (ctl.rot_en) begin
					ids_q[gi]   <= ids_q[(gi + 1) % MAX_ENTRIES];
					quals_q[gi] <= quals_q[(gi + 1) % MAX_ENTRIES];
				end
			end
		end
	endgenerate

	// status to controller
	always_comb begin
		sts.dump      = dump_q;
		sts.better    = better_q;
		sts.empty     = (count_q == '0);
		sts.step_last = (step_q == STEP_LAST);
		sts.sweep_hit = (step_ext + EXT_W'(1) == count_ext);
		sts.emit_here = (step_ext < dump_n);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_offer || ctl.emit_entry) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_offer) begin
			accepted      <= better_q && !dump_q;
			entry_count   <= count_ext[4:0];
			threshold     <= thr_q;
			entry_valid   <= 1'b0;
			rank          <= '0;
			entry_id      <= '0;
			entry_quality <= '0;
			last          <= 1'b1;
		end else if (ctl.emit_entry) begin
			accepted      <= 1'b0;
			entry_count   <= count_ext[4:0];
			threshold     <= thr_q;
			entry_valid   <= 1'b1;
			rank          <= step_ext[3:0];
			entry_id      <= ids_q[0];
			entry_quality <= quals_q[0];
			last          <= (step_ext + EXT_W'(1) == dump_n);
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/top_k_best_keeper_core.sv */
// -----------------------------------------------------------------------------
// top_k_best_keeper_core
// Keeps the MAX_ENTRIES best candidates sorted best first; offer and dump.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid / in_stall    | cmd, candidate_id, quality
//  out     | out_valid / out_stall  | accepted, entry_count, threshold,
//          |                        | entry_valid, rank, entry_id,
//          |                        | entry_quality, last
//  cfg     | cfg_we                 | cfg_index, cfg_data
//
// Rejected offer, empty dump: evaluate, then reply. Accepted offer: evaluate and
// insert, MAX_ENTRIES odd-even sort passes, then a MAX_ENTRIES-step ring sweep
// for the new threshold. Dump: one entry per ring step, up to count or DUMP_LIMIT.
// One transaction is in work at a time; the next is taken while the last result
// still waits in the output register. out_stall holds the sequencer only at a
// step with a result to load. Reset empties the list, loads register defaults.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module top_k_best_keeper_core #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [31:0]         candidate_id,
	input  logic signed [31:0]  quality,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                accepted,
	output logic [4:0]          entry_count,
	output logic signed [31:0]  threshold,
	output logic                entry_valid,
	output logic [3:0]          rank,
	output logic [31:0]         entry_id,
	output logic signed [31:0]  entry_quality,
	output logic                last
);

	tkbk_pkg::ctl_t ctl;
	tkbk_pkg::sts_t sts;

	tkbk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	tkbk_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.candidate_id  (candidate_id),
		.quality       (quality),
		.ctl           (ctl),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.accepted      (accepted),
		.entry_count   (entry_count),
		.threshold     (threshold),
		.entry_valid   (entry_valid),
		.rank          (rank),
		.entry_id      (entry_id),
		.entry_quality (entry_quality),
		.last          (last)
	);

endmodule

/* src/tkbk_checker.sv */
// -----------------------------------------------------------------------------
// tkbk_checker
// Port-level checks on the top-K keeper, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tkbk_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic accepted,
	input logic entry_valid,
	input logic last
);

	// a result held under stall stays offered
	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped under stall")

	// one transaction in work at a time: busy right after an accept
	`AST_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while busy")

	// offer replies and empty dumps are single-result transactions
	`AST_IMPL(a_reply_last, clk, arst_n, out_valid && !entry_valid, last, "reply without last")

	// an accepted offer never carries a dumped entry
	`AST_IMPL(a_acc_no_entry, clk, arst_n, out_valid && accepted, !entry_valid, "accepted on dump result")

endmodule

bind top_k_best_keeper_core tkbk_checker u_tkbk_checker (.*);
